// ----- sv/mt19937_generator_core_assert.svh -----
// Assertion macros for the generator's top-level RTL file.
`ifndef MT19937_GENERATOR_CORE_ASSERT_SVH
`define MT19937_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define MTG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mtg_pkg.sv -----
// Types and constants shared by the MT19937 generator modules.
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

	localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
	localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
	localparam logic [31:0] MT_TEMPER_B = 32'h9D2C_5680;
	localparam logic [31:0] MT_TEMPER_C = 32'hEFC6_0000;
	localparam int unsigned MT_SHIFT_M  = 397;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_DRAW_RD,
		ST_DRAW_FAR,
		ST_DRAW_CALC
	} mtg_state_t;

	typedef struct packed {
		logic seed_load;
		logic seed_mul;
		logic seed_add;
		logic far_sel;
		logic draw_capture;
		logic draw_commit;
	} mtg_cmd_t;

	typedef struct packed {
		logic seed_last;
		logic out_free;
	} mtg_status_t;

endpackage

`default_nettype wire

// ----- sv/mt19937_generator_core.sv -----
// Top level of the MT19937 32-bit pseudo-random generator.
`timescale 1ns / 1ps
`default_nettype none

// A draw item (func = 0) returns one tempered word on value; a reseed item
// (func = 1) loads the state from seed and returns nothing. The state is
// twisted one word per draw, just before that word is tempered; a draw passes
// through DRAW_RD, DRAW_FAR and DRAW_CALC, which read the two-port state
// memory, and then back to idle, where items are accepted; DRAW_CALC waits
// while the output register is full. A reseed keeps the input stalled while
// it writes words 1 to STATE_WORDS - 1, each through the 32 by 32 multiplier
// and the add that follows it. Until the first reseed every draw returns zero.
// A finished word waits in the output register while the next item is accepted.
module mt19937_generator_core #(
	parameter int unsigned STATE_WORDS = 624
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [31:0] seed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      value
);

	mtg_pkg::mtg_cmd_t    cmd;
	mtg_pkg::mtg_status_t status;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.status   (status),
		.cmd      (cmd)
	);

	mtg_datapath #(
		.STATE_WORDS (STATE_WORDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

`include "mt19937_generator_core_assert.svh"

	`MTG_ASSERT_SAME(a_seed_busy, cmd.seed_mul || cmd.seed_add, !in_ready,
		"Input accepted while the state is being reseeded.")
	`MTG_ASSERT_NEXT(a_commit_out, cmd.draw_commit && status.out_free, out_valid,
		"Committed draw did not reach the output register.")
	`MTG_ASSERT_SAME(a_load_accept, cmd.seed_load, in_valid && in_ready && func,
		"Reseed started without an accepted reseed item.")

endmodule

`default_nettype wire

// ----- sv/mtg_ctrl.sv -----
// Sequencer for reseed and draw operations of the MT19937 generator.
`timescale 1ns / 1ps
`default_nettype none

module mtg_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                func,
	input  wire mtg_pkg::mtg_status_t status,
	output mtg_pkg::mtg_cmd_t        cmd
);

	mtg_pkg::mtg_state_t state_q;
	mtg_pkg::mtg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mtg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func) begin
						cmd.seed_load = 1'b1;
						state_d       = mtg_pkg::ST_SEED_MUL;
					end else begin
						state_d = mtg_pkg::ST_DRAW_RD;
					end
				end
			end
			mtg_pkg::ST_SEED_MUL: begin
				cmd.seed_mul = 1'b1;
				state_d      = mtg_pkg::ST_SEED_ADD;
			end
			mtg_pkg::ST_SEED_ADD: begin
				cmd.seed_add = 1'b1;
				state_d      = status.seed_last ? mtg_pkg::ST_IDLE : mtg_pkg::ST_SEED_MUL;
			end
			mtg_pkg::ST_DRAW_RD: begin
				state_d = mtg_pkg::ST_DRAW_FAR;
			end
			mtg_pkg::ST_DRAW_FAR: begin
				cmd.far_sel      = 1'b1;
				cmd.draw_capture = 1'b1;
				state_d          = mtg_pkg::ST_DRAW_CALC;
			end
			mtg_pkg::ST_DRAW_CALC: begin
				cmd.far_sel     = 1'b1;
				cmd.draw_commit = 1'b1;
				if (status.out_free) begin
					state_d = mtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/mtg_datapath.sv -----
// State memory, seeding recurrence, per-word twist, tempering and output register.
`timescale 1ns / 1ps
`default_nettype none

module mtg_datapath #(
	parameter int unsigned STATE_WORDS = 624
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [31:0]         seed,
	input  wire mtg_pkg::mtg_cmd_t   cmd,
	output mtg_pkg::mtg_status_t     status,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [31:0]              value
);

	localparam int unsigned AW = $clog2(STATE_WORDS);

	logic [31:0] mem_q [STATE_WORDS];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	logic [AW-1:0] idx_q;
	logic [AW-1:0] k_q;
	logic          seeded_q;
	logic          out_valid_q;
	logic [31:0]   value_q;
	logic [31:0]   prev_q;
	logic [31:0]   prod_s1;
	logic [31:0]   nxt_q;

	logic [AW-1:0] idx_next;
	logic [AW:0]   far_sum;
	logic [AW-1:0] far_addr;
	logic [AW-1:0] rd_b_addr;
	logic [31:0]   seed_word;
	logic [31:0]   twist_x;
	logic [31:0]   twisted;
	logic          commit;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & mtg_pkg::MT_TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	assign idx_next  = (idx_q == AW'(STATE_WORDS - 1)) ? '0 : idx_q + AW'(1);
	assign far_sum   = {1'b0, idx_q} + (AW + 1)'(mtg_pkg::MT_SHIFT_M);
	assign far_addr  = (far_sum >= (AW + 1)'(STATE_WORDS))
		? AW'(far_sum - (AW + 1)'(STATE_WORDS)) : far_sum[AW-1:0];
	assign rd_b_addr = cmd.far_sel ? far_addr : idx_next;

	assign seed_word = prod_s1 + 32'(k_q);
	assign twist_x   = {rd_a_q[31], nxt_q[30:0]};
	assign twisted   = rd_b_q ^ (twist_x >> 1) ^ (twist_x[0] ? mtg_pkg::MT_MATRIX : 32'd0);

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.seed_last = (k_q == AW'(STATE_WORDS - 1));
	assign commit           = cmd.draw_commit && status.out_free;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = twisted;
		priority if (cmd.seed_load) begin
			we    = 1'b1;
			waddr = '0;
			wdata = seed;
		end else if (cmd.seed_add) begin
			we    = 1'b1;
			waddr = k_q;
			wdata = seed_word;
		end else if (commit && seeded_q) begin
			we = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[idx_q];
		rd_b_q <= mem_q[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			k_q         <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				idx_q    <= '0;
				k_q      <= AW'(1);
				seeded_q <= 1'b1;
			end else if (cmd.seed_add) begin
				k_q <= k_q + AW'(1);
			end else if (commit) begin
				idx_q <= idx_next;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			prev_q <= seed;
		end else if (cmd.seed_add) begin
			prev_q <= seed_word;
		end
		if (cmd.seed_mul) begin
			prod_s1 <= mtg_pkg::MT_INIT_MUL * (prev_q ^ (prev_q >> 30));
		end
		if (cmd.draw_capture) begin
			nxt_q <= rd_b_q;
		end
		if (commit) begin
			value_q <= seeded_q ? temper(twisted) : 32'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for mt19937_generator_core, with its own MT19937 model.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned N_WORDS = 624;
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_RESEED = 1'b1;
	localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
	localparam int IDLE_PCT = 17;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int N_DIRECTED = 16;

	typedef struct packed {
		logic        op;
		logic [31:0] seed;
		logic        known;
		logic [31:0] want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = OP_DRAW;
	logic [31:0] seed = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] value;

	logic [31:0] mt_words [N_WORDS];
	int unsigned mt_pos;
	logic [31:0] value_q [$];
	logic [31:0] rx_want;
	int          fail_count = 0;
	bit          no_idle = 1'b0;
	int          hold_ticket = 0;
	int          hold_served = 0;
	int          hold_left = 0;

	// Seed rows, draws before any reseed, and back-to-back reseeds.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_DRAW,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0000_0000},
		'{OP_RESEED, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{OP_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000},
		'{OP_RESEED, 32'd5489,      1'b0, 32'h0000_0000},
		'{OP_RESEED, 32'h0000_0001, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'h5555_5555, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000},
		'{OP_RESEED, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0000_0000}
	};

	mt19937_generator_core #(
		.STATE_WORDS(N_WORDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.seed(seed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void mt_load_seed(input logic [31:0] s);
		int unsigned k;
		logic [31:0] p;
		mt_words[0] = s;
		for (k = 1; k < N_WORDS; k++) begin
			p = mt_words[k - 1];
			mt_words[k] = mtg_pkg::MT_INIT_MUL * (p ^ (p >> 30)) + 32'(k);
		end
		mt_pos = N_WORDS;
	endfunction

	function automatic void mt_twist_all();
		int unsigned k;
		logic [31:0] x;
		logic [31:0] xa;
		for (k = 0; k < N_WORDS; k++) begin
			x = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % N_WORDS] & LOWER_MASK);
			xa = x >> 1;
			if (x[0]) begin
				xa = xa ^ mtg_pkg::MT_MATRIX;
			end
			mt_words[k] = mt_words[(k + mtg_pkg::MT_SHIFT_M) % N_WORDS] ^ xa;
		end
		mt_pos = 0;
	endfunction

	function automatic logic [31:0] mt_next_word();
		logic [31:0] y;
		if (mt_pos >= N_WORDS) begin
			mt_twist_all();
		end
		y = mt_words[mt_pos];
		mt_pos = (mt_pos + 1) & 32'h3FF;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::MT_TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	task automatic send_item(input logic op, input logic [31:0] s, input logic known,
			input logic [31:0] want);
		logic [31:0] predicted;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		seed <= s;
		do @(posedge clk); while (!in_ready);
		if (op == OP_DRAW) begin
			predicted = mt_next_word();
			value_q.push_back(known ? want : predicted);
		end else begin
			mt_load_seed(s);
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (value_q.size() != 0);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (value_q.size() == 0) begin
				$display("%0t: value with nothing expected, expected none, got %08h",
					$time, value);
				fail_count++;
			end else begin
				rx_want = value_q.pop_front();
				if (value !== rx_want) begin
					$display("%0t: value mismatch, expected %08h, got %08h",
						$time, rx_want, value);
					fail_count++;
				end
			end
		end
		if (hold_served != hold_ticket) begin
			hold_served = hold_ticket;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		for (int unsigned k = 0; k < N_WORDS; k++) begin
			mt_words[k] = '0;
		end
		mt_pos = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_item(directed_rows[i].op, directed_rows[i].seed, directed_rows[i].known,
				directed_rows[i].want);
		end

		// A long run of draws after one reseed crosses the twist point at word 624.
		send_item(OP_RESEED, $urandom(), 1'b0, '0);
		for (int i = 0; i < 700; i++) begin
			no_idle = (i >= 100 && i < 400);
			if (i == 450) begin
				hold_ticket++;
			end
			send_item(OP_DRAW, $urandom(), 1'b0, '0);
		end
		no_idle = 1'b0;
		wait_results_done();

		for (int i = 0; i < 500; i++) begin
			if ($urandom_range(99) < 2) begin
				send_item(OP_RESEED, $urandom(), 1'b0, '0);
			end else begin
				send_item(OP_DRAW, $urandom(), 1'b0, '0);
			end
		end
		wait_results_done();
		repeat (20) @(posedge clk);

		if (fail_count == 0) begin
			$display("** mt19937_generator_core: PASSED **");
		end else begin
			$display("** mt19937_generator_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("** mt19937_generator_core: FAILED **");
		$finish;
	end

endmodule
